@@ hdl/edfvd_pkg.sv @@
// edfvd_pkg: types and constants shared by the edf-vd job scheduler
// no dependencies; imported by every module of the scheduler but edfvd_ram

package edfvd_pkg;

	localparam int unsigned SCALE_W  = 17;
	localparam logic [SCALE_W-1:0] Q16_ONE = 17'h10000;

	localparam logic KIND_RELEASE = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [5:0]  task_id;
		logic [11:0] job_tag;
		logic [15:0] relative_deadline;
		logic        high_crit;
		logic [15:0] exec_ticks;
	} in_item_t;

	typedef struct packed {
		logic        release_ok;
		logic        table_full;
		logic        run_valid;
		logic [5:0]  run_task;
		logic [11:0] run_job;
		logic        switched;
		logic        finished;
		logic [31:0] time_now;
	} out_item_t;

	// one job table entry, held in the slot memory
	typedef struct packed {
		logic [5:0]  task_id;
		logic [11:0] job_tag;
		logic [31:0] deadline;
		logic [15:0] remaining;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_FIND,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic find_step;
		logic scan_step;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_tick;
		logic in_exec_zero;
		logic find_hit;
		logic find_last;
		logic scan_done;
		logic out_free;
	} ctl_sts_t;

endpackage

@@ hdl/edfvd_ram.sv @@
// edfvd_ram: generic single write port memory with registered read
// no package dependencies

module edfvd_ram #(
	parameter int unsigned WIDTH = 66,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/edfvd_ctrl.sv @@
// edfvd_ctrl: sequencing state machine of the scheduler
// depends on edfvd_pkg (state, command and status types)

module edfvd_ctrl
	import edfvd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (sts.in_tick) begin
						state_d = ST_SCAN;
					end else if (sts.in_exec_zero) begin
						state_d = ST_COMMIT;
					end else begin
						state_d = ST_SCALE;
					end
				end
			end
			ST_SCALE: state_d = ST_FIND;
			ST_FIND: begin
				if (sts.find_hit || sts.find_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCALE:  cmd.mul_en    = 1'b1;
			ST_FIND:   cmd.find_step = 1'b1;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_COMMIT: cmd.commit    = sts.out_free;
			default: ;
		endcase
	end

endmodule

@@ hdl/edfvd_dp.sv @@
// edfvd_dp: job table, slot scan, deadline scaling and result register
// depends on edfvd_pkg and edfvd_ram

module edfvd_dp
	import edfvd_pkg::*;
#(
	parameter int unsigned SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [SCALE_W-1:0] cfg_data,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data,
	input  ctl_cmd_t           cmd,
	output ctl_sts_t           sts
);

	localparam int unsigned IW    = $clog2(SLOTS);
	localparam int unsigned CNT_W = IW + 1;
	localparam int unsigned ENT_W = $bits(slot_entry_t);

	logic [SCALE_W-1:0] scale_x_q;
	in_item_t           item_q;
	logic [15:0]        eff_q;
	logic [SLOTS-1:0]   valid_q;
	logic [31:0]        time_q;
	logic [IW-1:0]      last_slot_q;
	logic               last_valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IW-1:0]      free_idx_q;
	logic               free_found_q;
	logic               pend_s1;
	logic [IW-1:0]      idx_s1;
	logic               best_found_q;
	logic [IW-1:0]      best_idx_q;
	slot_entry_t        best_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [SCALE_W-1:0] x_clamp;
	logic [32:0]        prod;
	logic [IW-1:0]      cnt_idx;
	logic               cnt_end;
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	slot_entry_t        ram_wentry;
	logic               ram_re;
	logic [ENT_W-1:0]   ram_rdata;
	slot_entry_t        rd_entry;
	logic               take_s1;
	logic [15:0]        rem_dec;
	logic               rel_store;
	out_item_t          res;

	assign cnt_idx  = cnt_q[IW-1:0];
	assign cnt_end  = (cnt_q == CNT_W'(SLOTS));
	assign rd_entry = slot_entry_t'(ram_rdata);

	// clamp x to 1.0, one 16 x 17 multiply registered before use
	assign x_clamp = (scale_x_q > Q16_ONE) ? Q16_ONE : scale_x_q;
	assign prod    = {17'd0, item_q.relative_deadline} * {16'd0, x_clamp};

	assign rem_dec   = best_q.remaining - 16'd1;
	assign rel_store = (item_q.exec_ticks != 16'd0) && free_found_q;

	// candidate replaces the best only on a strictly earlier deadline
	assign take_s1 = pend_s1 && valid_q[idx_s1] &&
		(!best_found_q || (rd_entry.deadline < best_q.deadline));

	assign ram_re = cmd.scan_step && !cnt_end;

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = best_idx_q;
		ram_wentry = best_q;
		if (cmd.commit) begin
			if (item_q.kind == KIND_TICK) begin
				ram_we               = best_found_q && (rem_dec != 16'd0);
				ram_wentry.remaining = rem_dec;
			end else begin
				ram_we               = rel_store;
				ram_waddr            = free_idx_q;
				ram_wentry.task_id   = item_q.task_id;
				ram_wentry.job_tag   = item_q.job_tag;
				ram_wentry.deadline  = time_q + {16'd0, eff_q};
				ram_wentry.remaining = item_q.exec_ticks;
			end
		end
	end

	always_comb begin
		res = '0;
		if (item_q.kind == KIND_TICK) begin
			res.time_now = time_q + 32'd1;
			if (best_found_q) begin
				res.run_valid = 1'b1;
				res.run_task  = best_q.task_id;
				res.run_job   = best_q.job_tag;
				res.switched  = !last_valid_q || (last_slot_q != best_idx_q);
				res.finished  = (rem_dec == 16'd0);
			end
		end else begin
			res.time_now   = time_q;
			res.release_ok = (item_q.exec_ticks == 16'd0) || free_found_q;
			res.table_full = (item_q.exec_ticks != 16'd0) && !free_found_q;
		end
	end

	edfvd_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ENT_W'(ram_wentry)),
		.re   (ram_re),
		.raddr(cnt_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q    <= Q16_ONE;
			valid_q      <= '0;
			time_q       <= '0;
			last_slot_q  <= '0;
			last_valid_q <= 1'b0;
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			pend_s1      <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				scale_x_q <= cfg_data;
			end
			if (cmd.load) begin
				cnt_q        <= '0;
				free_found_q <= 1'b0;
				pend_s1      <= 1'b0;
				best_found_q <= 1'b0;
			end
			if (cmd.find_step) begin
				if (!valid_q[cnt_idx]) begin
					free_found_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.scan_step) begin
				pend_s1 <= !cnt_end;
				if (!cnt_end) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (take_s1) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (item_q.kind == KIND_TICK) begin
					time_q <= time_q + 32'd1;
					if (best_found_q) begin
						last_slot_q <= best_idx_q;
						if (rem_dec == 16'd0) begin
							valid_q[best_idx_q] <= 1'b0;
							last_valid_q        <= 1'b0;
						end else begin
							last_valid_q <= 1'b1;
						end
					end
				end else if (rel_store) begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.mul_en) begin
			eff_q <= item_q.high_crit ? prod[31:16] : item_q.relative_deadline;
		end
		if (cmd.find_step) begin
			free_idx_q <= cnt_idx;
		end
		if (cmd.scan_step) begin
			idx_s1 <= cnt_idx;
			if (take_s1) begin
				best_idx_q <= idx_s1;
				best_q     <= rd_entry;
			end
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign sts.in_tick      = (in_data.kind == KIND_TICK);
	assign sts.in_exec_zero = (in_data.exec_ticks == 16'd0);
	assign sts.find_hit     = !valid_q[cnt_idx];
	assign sts.find_last    = (cnt_q == CNT_W'(SLOTS - 1));
	assign sts.scan_done    = cnt_end && !pend_s1;
	assign sts.out_free     = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/edf_vd_job_scheduler_unit.sv @@
// edf_vd_job_scheduler_unit: top level of the edf-vd job scheduler
// depends on edfvd_pkg, edfvd_ctrl, edfvd_dp (and edfvd_ram below it)

// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_data, scale_x in q16
// in        in         in_valid / in_ready    in_data, in_item_t
// out       out        out_valid / out_ready  out_data, out_item_t
//
// one item is worked on at a time; the slot memory (one read port) sets the pace
// tick: scan of every slot, then a drain of the registered read and the last compare,
//   then the commit
// release: scale, free slot search, commit; a release with zero execution time
//   goes straight from idle to commit
// reset clears the table valid bits, time and last-run state; no clearing pass
// a result waiting in the output register does not block the next input transfer;
//   only the commit of the following item waits for out_ready

module edf_vd_job_scheduler_unit
	import edfvd_pkg::*;
#(
	parameter int unsigned SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SCALE_W-1:0] cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// register writes must only arrive while idle; the block does not enforce this, and the port always takes them
	assign cfg_ready = 1'b1;

	// sequencing: idle, scale, find free slot, scan for earliest deadline, commit
	edfvd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// job table, time base, scan registers and the output register
	edfvd_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
